// ----- rtl/lpvs_pkg.sv -----
// ----------------------------------------------------------------------------
// lpvs_pkg
// types and codes shared by the value set modules, and the datapath's hash function
// ----------------------------------------------------------------------------
package lpvs_pkg;

  localparam int VAL_W       = 64;
  localparam int VAL_AW      = 10;              // value store address bits
  localparam int HASH_AW     = 11;              // hash table address bits
  localparam int CNT_W       = VAL_AW;
  localparam int ACT_W       = 3;
  localparam int GP_W        = VAL_AW + 1;      // store position incl. one past end
  localparam int VALUE_SLOTS = 1 << VAL_AW;
  localparam int HASH_SLOTS  = 1 << HASH_AW;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // actions
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EXISTS  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GETPOS  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GETNEXT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_POP     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd6;

  // key register source
  localparam logic [1:0] KEY_V    = 2'd0;
  localparam logic [1:0] KEY_SVAL = 2'd1;
  localparam logic [1:0] KEY_LAST = 2'd2;

  // hash table read
  localparam logic [1:0] HRD_NONE = 2'd0;
  localparam logic [1:0] HRD_HASH = 2'd1;
  localparam logic [1:0] HRD_SINC = 2'd2;
  localparam logic [1:0] HRD_CUR  = 2'd3;

  // hash table write
  localparam logic [2:0] HW_NONE  = 3'd0;
  localparam logic [2:0] HW_ZSLOT = 3'd1;
  localparam logic [2:0] HW_PSLOT = 3'd2;
  localparam logic [2:0] HW_ZCUR  = 3'd3;
  localparam logic [2:0] HW_ZCLR  = 3'd4;

  // cluster cursor
  localparam logic [1:0] CUR_NONE  = 2'd0;
  localparam logic [1:0] CUR_SLOT1 = 2'd1;
  localparam logic [1:0] CUR_INC   = 2'd2;

  // insert position source
  localparam logic [1:0] POS_HQ   = 2'd0;
  localparam logic [1:0] POS_CNT1 = 2'd1;
  localparam logic [1:0] POS_REM  = 2'd2;

  // store read
  localparam logic [1:0] SRD_NONE = 2'd0;
  localparam logic [1:0] SRD_HQ   = 2'd1;
  localparam logic [1:0] SRD_CNT  = 2'd2;
  localparam logic [1:0] SRD_GP   = 2'd3;

  // get position source
  localparam logic [1:0] GP_POS = 2'd0;
  localparam logic [1:0] GP_ONE = 2'd1;
  localparam logic [1:0] GP_E1  = 2'd2;

  // store write
  localparam logic [1:0] SW_NONE = 2'd0;
  localparam logic [1:0] SW_PUSH = 2'd1;
  localparam logic [1:0] SW_REM  = 2'd2;

  // count update
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  // result source
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_SVAL = 2'd1;
  localparam logic [1:0] RES_LAST = 2'd2;

  typedef struct packed {
    logic       ld_in;
    logic       key_ld;
    logic [1:0] key_src;
    logic       last_ld;
    logic [1:0] hrd;
    logic [2:0] hwr;
    logic [1:0] cur_op;
    logic       e_ld;
    logic       pos_ld;
    logic [1:0] pos_src;
    logic       rem_ld;
    logic [1:0] srd;
    logic       gp_ld;
    logic [1:0] gp_src;
    logic [1:0] swr;
    logic [1:0] cnt_op;
    logic       clr_inc;
    logic       res_ld;
    logic [1:0] res_src;
    logic       ok_ld;
    logic       ok_val;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             v_zero;
    logic             cnt_zero;
    logic             cnt_full;
    logic             hq_zero;
    logic             match;
    logic             sval_zero;
    logic             rem_is_last;
    logic             clr_last;
    logic             out_free;
  } st_t;

  // 13 * (v + rotr16 + rotr32 + rotr64) reduced to the table size
  function automatic logic [HASH_AW-1:0] hash_idx(input logic [VAL_W-1:0] v);
    logic [15:0]        r16;
    logic [31:0]        r32;
    logic [VAL_W-1:0]   r64;
    logic [VAL_W-1:0]   s;
    logic [HASH_AW-1:0] x;
    r16 = {v[12:0], v[15:13]};
    r32 = {v[16:0], v[31:17]};
    r64 = {v[22:0], v[63:23]};
    s   = v + {48'b0, r16} + {32'b0, r32} + r64;
    x   = s[HASH_AW-1:0];
    return (x << 3) + (x << 2) + x;
  endfunction

endpackage

// ----- rtl/linear_probe_value_set_top.sv -----
// get by position reads the value store directly; a lookup probes the hash table from the
// key's slot until a match or an empty slot, and a push that inserts probes for a free slot
// remove and pop walk the cluster after the freed slot and reinsert each entry found in it
// throughput: one item at a time, set by the hash walk; clear sweeps the whole hash table
// reset: synchronous, active low; afterwards a sweep zeroes the hash table
// with in_tready low; the value store is not cleared
// ----------------------------------------------------------------------------
// linear_probe_value_set_top
// set of unique non-zero 64-bit values with a linear-probing hash index
// ----------------------------------------------------------------------------
module linear_probe_value_set_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // item in: action [2:0], value [66:3], position [76:67], zero pad above
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lpvs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // item out: ok [0], result_value [64:1], count [74:65], zero pad above
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lpvs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lpvs_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  st_t  st;

  // sequencer: one action at a time, probe loops and cluster reinsertion
  lpvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // datapath: memories, cursors, count and the output register that
  // holds a finished item while the next one is taken
  lpvs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/lpvs_dp.sv -----
// ----------------------------------------------------------------------------
// lpvs_dp
// datapath: value store, hash table, cursors, count and output register
// ----------------------------------------------------------------------------
module lpvs_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lpvs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tready,
  input  lpvs_pkg::cmd_t                   cmd,
  output lpvs_pkg::st_t                    st,
  output logic                             out_tvalid,
  output logic [lpvs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lpvs_pkg::*;

  logic [VAL_W-1:0]   hmem_unused;
  logic [VAL_AW-1:0]  hmem [HASH_SLOTS];
  logic [VAL_W-1:0]   smem [VALUE_SLOTS];

  logic [ACT_W-1:0]   act_r;
  logic [VAL_W-1:0]   v_r;
  logic [VAL_AW-1:0]  posin_r;
  logic [VAL_W-1:0]   key_r;
  logic [VAL_W-1:0]   last_r;
  logic [HASH_AW-1:0] slot_r;
  logic [HASH_AW-1:0] cur_r;
  logic [HASH_AW-1:0] clr_r;
  logic [VAL_AW-1:0]  e_r;
  logic [VAL_AW-1:0]  pos_r;
  logic [VAL_AW-1:0]  rem_r;
  logic [GP_W-1:0]    gp_r;
  logic [CNT_W-1:0]   count_r;
  logic [VAL_AW-1:0]  hq_r;
  logic [VAL_W-1:0]   sq_r;
  logic               svalid_r;
  logic [VAL_W-1:0]   res_r;
  logic               ok_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [VAL_W-1:0]   out_res_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic [VAL_W-1:0]   sval;
  logic [HASH_AW-1:0] key_hash;
  logic               hr_en;
  logic [HASH_AW-1:0] hr_addr;
  logic               hw_en;
  logic [HASH_AW-1:0] hw_addr;
  logic [VAL_AW-1:0]  hw_data;
  logic               sr_en;
  logic [GP_W-1:0]    sr_addr;
  logic               sw_en;
  logic [VAL_AW-1:0]  sw_addr;
  logic [VAL_W-1:0]   sw_data;

  assign hmem_unused = '0;
  assign sval        = svalid_r ? sq_r : hmem_unused;
  assign key_hash    = hash_idx(key_r);

  // hash table ports
  always_comb begin
    hr_en   = cmd.hrd != HRD_NONE;
    hr_addr = cur_r;
    unique case (cmd.hrd)
      HRD_HASH: hr_addr = key_hash;
      HRD_SINC: hr_addr = slot_r + 1'b1;
      default:  hr_addr = cur_r;
    endcase
    hw_en   = cmd.hwr != HW_NONE;
    hw_addr = slot_r;
    hw_data = '0;
    unique case (cmd.hwr)
      HW_PSLOT: hw_data = pos_r;
      HW_ZCUR:  hw_addr = cur_r;
      HW_ZCLR:  hw_addr = clr_r;
      default:  hw_addr = slot_r;
    endcase
  end

  // value store ports
  always_comb begin
    sr_en = cmd.srd != SRD_NONE;
    unique case (cmd.srd)
      SRD_HQ:  sr_addr = {1'b0, hq_r};
      SRD_CNT: sr_addr = {1'b0, count_r};
      default: sr_addr = gp_r;
    endcase
    sw_en   = cmd.swr != SW_NONE;
    sw_addr = rem_r;
    sw_data = last_r;
    if (cmd.swr == SW_PUSH) begin
      sw_addr = count_r + 1'b1;
      sw_data = v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hmem[hw_addr] <= hw_data;
    end
    if (hr_en) begin
      hq_r <= hmem[hr_addr];
    end
    if (sw_en) begin
      smem[sw_addr] <= sw_data;
    end
    if (sr_en) begin
      sq_r     <= smem[sr_addr[VAL_AW-1:0]];
      svalid_r <= (sr_addr != '0) && (sr_addr <= {1'b0, count_r});
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act_r   <= in_tdata[2:0];
      v_r     <= in_tdata[66:3];
      posin_r <= in_tdata[76:67];
    end
    if (cmd.key_ld) begin
      unique case (cmd.key_src)
        KEY_SVAL: key_r <= sval;
        KEY_LAST: key_r <= last_r;
        default:  key_r <= v_r;
      endcase
    end
    if (cmd.last_ld) begin
      last_r <= sval;
    end
    if (cmd.hrd == HRD_HASH) begin
      slot_r <= key_hash;
    end else if (cmd.hrd == HRD_SINC) begin
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.cur_op == CUR_SLOT1) begin
      cur_r <= slot_r + 1'b1;
    end else if (cmd.cur_op == CUR_INC) begin
      cur_r <= cur_r + 1'b1;
    end
    if (cmd.e_ld) begin
      e_r <= hq_r;
    end
    if (cmd.pos_ld) begin
      unique case (cmd.pos_src)
        POS_CNT1: pos_r <= count_r + 1'b1;
        POS_REM:  pos_r <= rem_r;
        default:  pos_r <= hq_r;
      endcase
    end
    if (cmd.rem_ld) begin
      rem_r <= e_r;
    end
    if (cmd.gp_ld) begin
      unique case (cmd.gp_src)
        GP_ONE:  gp_r <= GP_W'(1);
        GP_E1:   gp_r <= {1'b0, e_r} + 1'b1;
        default: gp_r <= {1'b0, posin_r} + 1'b1;
      endcase
    end
    if (cmd.res_ld) begin
      unique case (cmd.res_src)
        RES_SVAL: res_r <= sval;
        RES_LAST: res_r <= last_r;
        default:  res_r <= '0;
      endcase
    end
    if (cmd.ok_ld) begin
      ok_r <= cmd.ok_val;
    end
    if (cmd.out_ld) begin
      out_ok_r  <= ok_r;
      out_res_r <= res_r;
      out_cnt_r <= count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_INC: count_r <= count_r + 1'b1;
        CNT_DEC: count_r <= count_r - 1'b1;
        CNT_CLR: count_r <= '0;
        default: count_r <= count_r;
      endcase
      if (cmd.clr_inc) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.act         = act_r;
  assign st.v_zero      = v_r == '0;
  assign st.cnt_zero    = count_r == '0;
  assign st.cnt_full    = &count_r;
  assign st.hq_zero     = hq_r == '0;
  assign st.match       = sval == key_r;
  assign st.sval_zero   = sval == '0;
  assign st.rem_is_last = rem_r == count_r;
  assign st.clr_last    = &clr_r;
  assign st.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_res_r, out_ok_r};

endmodule

// ----- rtl/lpvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpvs_ctrl
// controller: sequences lookups, inserts and cluster removal per action
// ----------------------------------------------------------------------------
module lpvs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  lpvs_pkg::st_t  st,
  output logic           in_tready,
  output lpvs_pkg::cmd_t cmd
);
  import lpvs_pkg::*;

  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DISP     = 5'd2;
  localparam logic [4:0] S_CLR      = 5'd3;
  localparam logic [4:0] S_LAST_RD  = 5'd4;
  localparam logic [4:0] S_LAST_LAT = 5'd5;
  localparam logic [4:0] S_LK_ST    = 5'd6;
  localparam logic [4:0] S_LK_E     = 5'd7;
  localparam logic [4:0] S_LK_CMP   = 5'd8;
  localparam logic [4:0] S_INS_ST   = 5'd9;
  localparam logic [4:0] S_INS_E    = 5'd10;
  localparam logic [4:0] S_HR_ST    = 5'd11;
  localparam logic [4:0] S_HR_RD    = 5'd12;
  localparam logic [4:0] S_HR_E     = 5'd13;
  localparam logic [4:0] S_HR_V     = 5'd14;
  localparam logic [4:0] S_HR_IST   = 5'd15;
  localparam logic [4:0] S_HR_INS   = 5'd16;
  localparam logic [4:0] S_GET_RD   = 5'd17;
  localparam logic [4:0] S_GET_LAT  = 5'd18;
  localparam logic [4:0] S_NEXT     = 5'd19;
  localparam logic [4:0] S_OUT      = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      step_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    unique case (state_r)
      S_INIT: begin
        cmd.hwr     = HW_ZCLR;
        cmd.clr_inc = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_ld  = 1'b1;
        cmd.res_src = RES_ZERO;
        cmd.ok_ld   = 1'b1;
        cmd.ok_val  = 1'b0;
        cmd.key_src = KEY_V;
        step_nxt    = '0;
        state_nxt   = S_OUT;
        unique case (st.act)
          ACT_PUSH: begin
            if (!st.v_zero && !st.cnt_full) begin
              cmd.key_ld = 1'b1;
              state_nxt  = S_LK_ST;
            end
          end
          ACT_REMOVE: begin
            if (!st.v_zero && !st.cnt_zero) begin
              cmd.key_ld = 1'b1;
              state_nxt  = S_LK_ST;
            end
          end
          ACT_EXISTS: begin
            cmd.key_ld = 1'b1;
            state_nxt  = S_LK_ST;
          end
          ACT_GETPOS: begin
            cmd.gp_ld  = 1'b1;
            cmd.gp_src = GP_POS;
            state_nxt  = S_GET_RD;
          end
          ACT_GETNEXT: begin
            if (st.v_zero) begin
              cmd.gp_ld  = 1'b1;
              cmd.gp_src = GP_ONE;
              state_nxt  = S_GET_RD;
            end else begin
              cmd.key_ld = 1'b1;
              state_nxt  = S_LK_ST;
            end
          end
          ACT_POP: begin
            if (!st.cnt_zero) state_nxt = S_LAST_RD;
          end
          ACT_CLEAR: state_nxt = S_CLR;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_CLR: begin
        cmd.hwr     = HW_ZCLR;
        cmd.clr_inc = 1'b1;
        if (st.clr_last) begin
          cmd.cnt_op = CNT_CLR;
          cmd.ok_ld  = 1'b1;
          cmd.ok_val = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_LAST_RD: begin
        cmd.srd   = SRD_CNT;
        state_nxt = S_LAST_LAT;
      end
      S_LAST_LAT: begin
        cmd.last_ld = 1'b1;
        cmd.key_ld  = 1'b1;
        cmd.key_src = KEY_SVAL;
        step_nxt    = 3'd1;
        state_nxt   = S_LK_ST;
      end
      S_LK_ST: begin
        cmd.hrd   = HRD_HASH;
        state_nxt = S_LK_E;
      end
      S_LK_E: begin
        if (st.hq_zero) begin
          found_nxt = 1'b0;
          state_nxt = S_NEXT;
        end else begin
          cmd.e_ld  = 1'b1;
          cmd.srd   = SRD_HQ;
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (st.match) begin
          found_nxt = 1'b1;
          state_nxt = S_NEXT;
        end else begin
          cmd.hrd   = HRD_SINC;
          state_nxt = S_LK_E;
        end
      end
      S_INS_ST: begin
        cmd.hrd   = HRD_HASH;
        state_nxt = S_INS_E;
      end
      S_INS_E: begin
        if (st.hq_zero) begin
          cmd.hwr   = HW_PSLOT;
          state_nxt = S_NEXT;
        end else begin
          cmd.hrd = HRD_SINC;
        end
      end
      S_HR_ST: begin
        cmd.hwr    = HW_ZSLOT;
        cmd.cur_op = CUR_SLOT1;
        state_nxt  = S_HR_RD;
      end
      S_HR_RD: begin
        cmd.hrd   = HRD_CUR;
        state_nxt = S_HR_E;
      end
      S_HR_E: begin
        if (st.hq_zero) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.hwr     = HW_ZCUR;
          cmd.pos_ld  = 1'b1;
          cmd.pos_src = POS_HQ;
          cmd.srd     = SRD_HQ;
          state_nxt   = S_HR_V;
        end
      end
      S_HR_V: begin
        if (st.sval_zero) begin
          cmd.cur_op = CUR_INC;
          state_nxt  = S_HR_RD;
        end else begin
          cmd.key_ld  = 1'b1;
          cmd.key_src = KEY_SVAL;
          state_nxt   = S_HR_IST;
        end
      end
      S_HR_IST: begin
        cmd.hrd   = HRD_HASH;
        state_nxt = S_HR_INS;
      end
      S_HR_INS: begin
        if (st.hq_zero) begin
          cmd.hwr    = HW_PSLOT;
          cmd.cur_op = CUR_INC;
          state_nxt  = S_HR_RD;
        end else begin
          cmd.hrd = HRD_SINC;
        end
      end
      S_GET_RD: begin
        cmd.srd   = SRD_GP;
        state_nxt = S_GET_LAT;
      end
      S_GET_LAT: begin
        cmd.res_ld  = 1'b1;
        cmd.res_src = RES_SVAL;
        cmd.ok_ld   = 1'b1;
        cmd.ok_val  = !st.sval_zero;
        state_nxt   = S_OUT;
      end
      S_NEXT: begin
        state_nxt = S_OUT;
        unique case (st.act)
          ACT_PUSH: begin
            if (step_r == 3'd0) begin
              if (!found_r) begin
                cmd.cnt_op  = CNT_INC;
                cmd.swr     = SW_PUSH;
                cmd.pos_ld  = 1'b1;
                cmd.pos_src = POS_CNT1;
                step_nxt    = 3'd1;
                state_nxt   = S_INS_ST;
              end
            end else begin
              cmd.ok_ld  = 1'b1;
              cmd.ok_val = 1'b1;
            end
          end
          ACT_REMOVE, ACT_POP: begin
            unique case (step_r)
              3'd0: begin
                if (found_r) begin
                  cmd.rem_ld = 1'b1;
                  state_nxt  = S_LAST_RD;
                end
              end
              3'd1: begin
                if (found_r) begin
                  step_nxt  = 3'd2;
                  state_nxt = S_HR_ST;
                end
              end
              3'd2: begin
                cmd.cnt_op = CNT_DEC;
                if (st.act == ACT_POP) begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_src = RES_LAST;
                  cmd.ok_ld   = 1'b1;
                  cmd.ok_val  = 1'b1;
                end else if (st.rem_is_last) begin
                  cmd.ok_ld  = 1'b1;
                  cmd.ok_val = 1'b1;
                end else begin
                  cmd.key_ld  = 1'b1;
                  cmd.key_src = KEY_V;
                  step_nxt    = 3'd3;
                  state_nxt   = S_LK_ST;
                end
              end
              3'd3: begin
                if (found_r) begin
                  step_nxt  = 3'd4;
                  state_nxt = S_HR_ST;
                end else begin
                  cmd.ok_ld  = 1'b1;
                  cmd.ok_val = 1'b1;
                end
              end
              3'd4: begin
                cmd.swr     = SW_REM;
                cmd.pos_ld  = 1'b1;
                cmd.pos_src = POS_REM;
                cmd.key_ld  = 1'b1;
                cmd.key_src = KEY_LAST;
                step_nxt    = 3'd5;
                state_nxt   = S_INS_ST;
              end
              default: begin
                cmd.ok_ld  = 1'b1;
                cmd.ok_val = 1'b1;
              end
            endcase
          end
          ACT_EXISTS: begin
            cmd.ok_ld  = 1'b1;
            cmd.ok_val = found_r;
          end
          ACT_GETNEXT: begin
            if (found_r) begin
              cmd.gp_ld  = 1'b1;
              cmd.gp_src = GP_E1;
              state_nxt  = S_GET_RD;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- sim/tb_linear_probe_value_set_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_value_set_top
// self-checking bench for the linear-probing value set: every accepted item
// is run through a local model of the store and hash index, and each result
// item is compared field by field with the oldest expected result
// ----------------------------------------------------------------------------
module tb_linear_probe_value_set_top;
  import lpvs_pkg::*;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
  } set_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // model state of the set
  logic [VAL_W-1:0]  mdl_store [VALUE_SLOTS];
  logic [CNT_W-1:0]  mdl_index [HASH_SLOTS];
  int unsigned       mdl_count;

  set_result_t       pending_results [$];
  logic [VAL_W-1:0]  value_pool [$];
  int unsigned       cycle_cnt = 0;
  int unsigned       fail_cnt = 0;
  int unsigned       items_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  linear_probe_value_set_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // action [2:0], value [66:3], position [76:67]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // ok [0], result_value [64:1], count [74:65]
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hash: 13 * (v + rotated low 16 + rotated low 32 + rotated 64), low 11 bits
  function automatic int unsigned slot_of(logic [VAL_W-1:0] v);
    logic [15:0]      rot16;
    logic [31:0]      rot32;
    logic [VAL_W-1:0] sum;
    rot16 = {v[12:0], v[15:13]};
    rot32 = {v[16:0], v[31:17]};
    sum = v + {48'b0, rot16} + {32'b0, rot32} + ((v >> 23) | (v << 41));
    sum = sum * 13;
    return sum % HASH_SLOTS;
  endfunction

  // store reads beyond the count see zero
  function automatic logic [VAL_W-1:0] stored_at(int unsigned pos);
    if (pos == 0 || pos > mdl_count || pos >= VALUE_SLOTS) return '0;
    return mdl_store[pos];
  endfunction

  function automatic bit find_slot(logic [VAL_W-1:0] v, output int unsigned slot);
    int unsigned s;
    s = slot_of(v);
    slot = 0;
    for (int n = 0; n < HASH_SLOTS; n++) begin
      if (mdl_index[s] == 0) return 1'b0;
      if (stored_at(mdl_index[s]) == v) begin
        slot = s;
        return 1'b1;
      end
      s = (s + 1) % HASH_SLOTS;
    end
    return 1'b0;
  endfunction

  function automatic void index_insert(int unsigned pos);
    logic [VAL_W-1:0] v;
    int unsigned s;
    v = stored_at(pos);
    if (v == 0) return;
    s = slot_of(v);
    for (int n = 0; n < HASH_SLOTS; n++) begin
      if (mdl_index[s] == 0) begin
        mdl_index[s] = CNT_W'(pos);
        return;
      end
      s = (s + 1) % HASH_SLOTS;
    end
  endfunction

  // clear one entry, then reinsert the rest of its cluster
  function automatic void index_remove(int unsigned slot);
    int unsigned t;
    int unsigned e;
    mdl_index[slot] = '0;
    for (int j = 1; j < HASH_SLOTS; j++) begin
      t = (slot + j) % HASH_SLOTS;
      e = mdl_index[t];
      if (e == 0) return;
      mdl_index[t] = '0;
      index_insert(e);
    end
  endfunction

  function automatic set_result_t predict_set_op(logic [ACT_W-1:0] act,
                                                 logic [VAL_W-1:0] v,
                                                 logic [CNT_W-1:0] pos);
    set_result_t r;
    int unsigned slot, last_slot, rem_pos, last_pos;
    logic [VAL_W-1:0] last_val;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (v != 0 && !find_slot(v, slot) && mdl_count + 1 < VALUE_SLOTS) begin
          mdl_count++;
          mdl_store[mdl_count] = v;
          index_insert(mdl_count);
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (v != 0 && mdl_count != 0 && find_slot(v, slot)) begin
          last_pos = mdl_count;
          last_val = stored_at(last_pos);
          rem_pos = mdl_index[slot];
          if (find_slot(last_val, last_slot)) begin
            index_remove(last_slot);
            mdl_count--;
            if (rem_pos != last_pos && find_slot(v, slot)) begin
              index_remove(slot);
              mdl_store[rem_pos] = last_val;
              index_insert(rem_pos);
            end
            r.ok = 1'b1;
          end
        end
      end
      ACT_EXISTS: r.ok = find_slot(v, slot);
      ACT_GETPOS: begin
        r.value = stored_at(int'(pos) + 1);
        r.ok = r.value != 0;
      end
      ACT_GETNEXT: begin
        if (v == 0) r.value = stored_at(1);
        else if (find_slot(v, slot)) r.value = stored_at(int'(mdl_index[slot]) + 1);
        r.ok = r.value != 0;
      end
      ACT_POP: begin
        if (mdl_count != 0) begin
          last_val = stored_at(mdl_count);
          if (find_slot(last_val, last_slot)) begin
            index_remove(last_slot);
            mdl_count--;
            r.value = last_val;
            r.ok = 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        foreach (mdl_index[i]) mdl_index[i] = '0;
        mdl_count = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = CNT_W'(mdl_count);
    return r;
  endfunction

  // drive one item, hold it until accepted, then record its expected result
  task automatic send_item(logic [ACT_W-1:0] act, logic [VAL_W-1:0] v,
                           logic [CNT_W-1:0] pos = '0);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(6, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pos, v, act};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_set_op(act, v, pos));
    items_sent++;
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // result checker
  always @(posedge clk) begin
    set_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_tdata[0]);
          fail_cnt++;
        end
        if (out_tdata[64:1] !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_tdata[64:1]);
          fail_cnt++;
        end
        if (out_tdata[74:65] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_tdata[74:65]);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** linear_probe_value_set_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // a nonzero value whose hash lands on the given slot
  function automatic logic [VAL_W-1:0] value_for_slot(int unsigned slot);
    logic [VAL_W-1:0] v;
    do v = rand_value(); while (v == 0 || slot_of(v) != slot);
    return v;
  endfunction

  task automatic test_directed();
    logic [VAL_W-1:0] all_ones;
    all_ones = '1;
    send_item(ACT_POP, '0);                 // pop on empty set
    send_item(ACT_GETNEXT, '0);             // get next from zero, empty
    send_item(ACT_PUSH, '0);                // zero is reserved
    send_item(ACT_PUSH, all_ones);
    send_item(ACT_PUSH, 64'd1);
    send_item(ACT_PUSH, 64'h8000_0000_0000_0000);
    send_item(ACT_PUSH, 64'd1);             // duplicate
    send_item(ACT_EXISTS, all_ones);
    send_item(ACT_EXISTS, 64'd2);           // missing
    send_item(ACT_EXISTS, '0);
    send_item(ACT_GETPOS, '0, 10'd0);
    send_item(ACT_GETPOS, '0, 10'd2);
    send_item(ACT_GETPOS, '0, 10'd3);       // past the count
    send_item(ACT_GETPOS, all_ones, 10'h3ff);
    send_item(ACT_GETNEXT, '0);
    send_item(ACT_GETNEXT, 64'd1);
    send_item(ACT_GETNEXT, 64'h8000_0000_0000_0000);  // last value
    send_item(ACT_GETNEXT, 64'd5);          // missing
    send_item(ACT_REMOVE, '0);
    send_item(ACT_REMOVE, 64'd7);           // missing
    send_item(ACT_REMOVE, all_ones);        // hole filled by the last value
    send_item(ACT_UNUSED, all_ones, 10'h3ff);
    send_item(ACT_POP, '0);
    send_item(ACT_CLEAR, '0);
    send_item(ACT_EXISTS, 64'd1);
    go_idle();
  endtask

  // colliding values build clusters, also across the table wrap
  task automatic test_clusters();
    logic [VAL_W-1:0] hot [12];
    foreach (hot[i]) hot[i] = value_for_slot(i < 6 ? 100 : (i < 9 ? HASH_SLOTS - 1 : 0));
    foreach (hot[i]) begin
      send_item(ACT_PUSH, hot[i]);
      value_pool.push_back(hot[i]);
    end
    send_item(ACT_REMOVE, hot[1]);
    send_item(ACT_EXISTS, hot[5]);
    send_item(ACT_REMOVE, hot[6]);
    send_item(ACT_EXISTS, hot[8]);
    send_item(ACT_EXISTS, hot[11]);
    send_item(ACT_GETNEXT, hot[0]);
    send_item(ACT_POP, '0);
    send_item(ACT_REMOVE, hot[0]);
    send_item(ACT_EXISTS, hot[4]);
    send_item(ACT_CLEAR, '0);
    go_idle();
  endtask

  // fill the store to its limit
  task automatic test_full_store();
    for (int i = 0; i < VALUE_SLOTS - 1; i++) send_item(ACT_PUSH, {$urandom, 22'd0, i[9:0]} + 1);
    send_item(ACT_PUSH, 64'hdead_beef_0000_0001);  // full
    send_item(ACT_GETPOS, '0, 10'd1021);
    send_item(ACT_GETPOS, '0, 10'd1022);
    send_item(ACT_GETPOS, '0, 10'd1023);
    send_item(ACT_POP, '0);
    send_item(ACT_PUSH, 64'hdead_beef_0000_0001);
    send_item(ACT_CLEAR, '0);
    go_idle();
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned pick;
    logic [ACT_W-1:0] act;
    logic [VAL_W-1:0] v;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(999);
      if (pick < 350) act = ACT_PUSH;
      else if (pick < 560) act = ACT_REMOVE;
      else if (pick < 700) act = ACT_EXISTS;
      else if (pick < 800) act = ACT_GETPOS;
      else if (pick < 900) act = ACT_GETNEXT;
      else if (pick < 975) act = ACT_POP;
      else if (pick < 985) act = ACT_CLEAR;
      else act = ACT_UNUSED;
      pick = $urandom_range(99);
      if (pick < 75) v = value_pool[$urandom_range(value_pool.size() - 1)];
      else if (pick < 80) v = '0;
      else v = rand_value();
      send_item(act, v, pick < 50 ? CNT_W'($urandom_range(40)) : CNT_W'($urandom));
    end
    go_idle();
  endtask

  initial begin
    foreach (mdl_index[i]) mdl_index[i] = '0;
    mdl_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 40; i++) value_pool.push_back(rand_value());
    for (int i = 0; i < 12; i++) value_pool.push_back(value_for_slot(500 + i / 3));
    value_pool.push_back('1);
    value_pool.push_back(64'd1);

    test_directed();
    test_clusters();
    test_full_store();

    send_idle_pct = 33;
    recv_stall_pct = 66;
    test_random_mix(40);
    send_idle_pct = 66;
    recv_stall_pct = 33;
    test_random_mix(40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(40);

    repeat (20) @(posedge clk);
    $display("covered %0d items (push, remove, lookups, get by position, get next, pop,",
             items_sent);
    $display("clear, unused code, full store, hash clusters); %0d results checked",
             results_seen);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("** linear_probe_value_set_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, pending_results.size());
      $display("** linear_probe_value_set_top: FAILED **");
    end
    $finish;
  end

endmodule
